// ===== src/polyphase_interpolating_fir_defines.svh =====
// assertion macros for the polyphase interpolator
// expect clk and arst_n in the scope of use
`ifndef POLYPHASE_INTERPOLATING_FIR_DEFINES_SVH
`define POLYPHASE_INTERPOLATING_FIR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PIF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PIF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pif_pkg.sv =====
// shared types and constants of the polyphase interpolator
// no dependencies
`timescale 1ns / 1ps
package pif_pkg;
	localparam int SYM_W      = 8;
	localparam int HIST_W     = 9;
	localparam int COEF_W     = 16;
	localparam int IDX_W      = 7;
	localparam int DAC_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 9;
	localparam int OUT_GAIN   = 250;

	typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic signed [SYM_W-1:0]      sym_t;
	typedef logic signed [HIST_W-1:0]     hist_t;
	typedef logic signed [COEF_W-1:0]     coef_t;
	typedef logic        [IDX_W-1:0]      coef_idx_t;
	typedef logic        [DAC_W-1:0]      dac_t;

	localparam cfg_idx_t CFG_INVERT = 2'd0;
	localparam cfg_idx_t CFG_IDLE   = 2'd1;
	localparam dac_t     IDLE_RESET = 16'd2048;

	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_FILT = 3'b100
	} state_t;
endpackage

// ===== src/pif_in_if.sv =====
// request channel carrying symbols and coefficient loads
// depends on pif_pkg
`timescale 1ns / 1ps
interface pif_in_if;
	import pif_pkg::*;
	logic      valid;
	logic      ready;
	logic      cmd;
	sym_t      symbol;
	coef_idx_t coef_index;
	coef_t     coef_value;
	modport source (output valid, cmd, symbol, coef_index, coef_value, input ready);
	modport sink (input valid, cmd, symbol, coef_index, coef_value, output ready);
endinterface

// ===== src/pif_out_if.sv =====
// request channel carrying dac samples
// depends on pif_pkg
`timescale 1ns / 1ps
interface pif_out_if;
	import pif_pkg::*;
	logic valid;
	logic ready;
	dac_t dac_sample;
	logic last_phase;
	modport source (output valid, dac_sample, last_phase, input ready);
	modport sink (input valid, dac_sample, last_phase, output ready);
endinterface

// ===== src/pif_cfg_if.sv =====
// register write channel
// depends on pif_pkg
`timescale 1ns / 1ps
interface pif_cfg_if;
	import pif_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/polyphase_interpolating_fir.sv =====
// polyphase interpolating fir, top level
// depends on pif_pkg, pif_in_if, pif_out_if, pif_cfg_if, pif_ram and the defines header
`timescale 1ns / 1ps
`include "polyphase_interpolating_fir_defines.svh"

// A filter request (cmd 0) pushes one symbol, negated when the invert register is set, into
// the tap history and yields PHASE_COUNT dac samples, the last one flagged by last_phase.
// Coefficients sit in a ram with one row of TAPS_PER_PHASE_N taps per phase; one row is
// read per cycle unless the output stalls; each row passes the registered ram read and
// the product, sum and output registers. A new request is taken only in idle, after the
// last row of a symbol is issued. A load request (cmd 1) is a read-modify-write of one
// row; loads to slots at or beyond PHASE_COUNT * TAPS_PER_PHASE_N are dropped. The
// coefficient ram has no reset: every slot must be loaded before the first symbol.
// Register writes are always taken and belong to times when the block is idle.
module polyphase_interpolating_fir #(
	parameter int TAPS_PER_PHASE_N = 9,
	parameter int PHASE_COUNT      = 10,
	parameter int COEF_FRAC_BITS   = 15
) (
	input  logic     clk,
	input  logic     arst_n,
	pif_in_if.sink   sym,
	pif_out_if.source dac,
	pif_cfg_if.sink  cfg
);
	import pif_pkg::*;

	localparam int PW     = $clog2(PHASE_COUNT);
	localparam int TW     = $clog2(TAPS_PER_PHASE_N);
	localparam int ROW_W  = TAPS_PER_PHASE_N * COEF_W;
	localparam int SLOTS  = PHASE_COUNT * TAPS_PER_PHASE_N;
	localparam int CW     = $clog2(SLOTS) + 1;
	localparam int SLOT_W = (CW > IDX_W) ? CW : IDX_W;
	localparam int PROD_W = HIST_W + COEF_W;
	localparam int ACC_W  = PROD_W + TW + 1;
	localparam int SA     = ACC_W + GAIN_W;
	localparam int SB     = DAC_W + COEF_FRAC_BITS;
	localparam int SUM_W  = ((SA > SB) ? SA : SB) + 2;
	localparam logic [PW-1:0] PH_LAST = PW'(PHASE_COUNT - 1);
	localparam logic signed [SUM_W-1:0] GAIN = SUM_W'(OUT_GAIN);

	state_t state_q;
	logic [PW-1:0] ph_q;
	logic invert_q;
	dac_t idle_q;
	hist_t hist_q [TAPS_PER_PHASE_N];

	logic en;
	logic accept;
	logic issue;
	logic rd_en;
	logic [PW-1:0] rd_addr;
	logic [ROW_W-1:0] rd_data;
	logic wr_en;
	logic [ROW_W-1:0] wr_row;

	logic [SLOT_W-1:0] slot;
	logic [PW-1:0] ld_row;
	logic [TW-1:0] ld_tap;
	logic ld_ok;
	logic [PW-1:0] ld_row_q;
	logic [TW-1:0] ld_tap_q;
	coef_t ld_val_q;
	logic ld_ok_q;
	hist_t x_new;

	logic v_s1, v_s2, v_s3, out_valid_q;
	logic last_s1, last_s2, last_s3, last_q;
	logic signed [PROD_W-1:0] prod_s2 [TAPS_PER_PHASE_N];
	logic signed [PROD_W-1:0] prod [TAPS_PER_PHASE_N];
	logic signed [ACC_W-1:0] acc_s3;
	logic signed [ACC_W-1:0] acc;
	logic signed [SUM_W-1:0] idle_ext;
	logic signed [SUM_W-1:0] sum;
	dac_t sample;
	dac_t dac_q;

	// register port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
			idle_q   <= IDLE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_INVERT: invert_q <= cfg.data[0];
				CFG_IDLE:   idle_q   <= cfg.data;
				default:    ;
			endcase
		end
	end

	// control
	assign en        = !out_valid_q || dac.ready;
	assign sym.ready = (state_q == ST_IDLE) && (!v_s1 || en);
	assign accept    = sym.valid && sym.ready;
	assign issue     = state_q == ST_FILT;
	assign rd_en     = (issue && en) || (accept && sym.cmd == CMD_LOAD);
	assign rd_addr   = issue ? ph_q : ld_row;
	assign wr_en     = (state_q == ST_LOAD) && ld_ok_q;

	always_comb begin
		slot   = SLOT_W'(sym.coef_index);
		ld_ok  = slot < SLOT_W'(SLOTS);
		ld_row = '0;
		for (int p = 1; p < PHASE_COUNT; p++) begin
			if (slot >= SLOT_W'(p * TAPS_PER_PHASE_N)) begin
				ld_row = PW'(p);
			end
		end
		ld_tap = TW'(slot - SLOT_W'(ld_row) * SLOT_W'(TAPS_PER_PHASE_N));
	end

	always_comb begin
		wr_row = rd_data;
		wr_row[ld_tap_q * COEF_W +: COEF_W] = ld_val_q;
	end

	assign x_new = invert_q ? -HIST_W'(sym.symbol) : HIST_W'(sym.symbol);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (sym.cmd == CMD_LOAD) ? ST_LOAD : ST_FILT;
					end
				end
				ST_LOAD: state_q <= ST_IDLE;
				ST_FILT: begin
					if (en) begin
						if (ph_q == PH_LAST) begin
							ph_q    <= '0;
							state_q <= ST_IDLE;
						end else begin
							ph_q <= ph_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS_PER_PHASE_N; k++) begin
				hist_q[k] <= '0;
			end
		end else if (accept && sym.cmd == CMD_FILTER) begin
			hist_q[0] <= x_new;
			for (int k = 1; k < TAPS_PER_PHASE_N; k++) begin
				hist_q[k] <= hist_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_ok_q <= 1'b0;
		end else if (accept && sym.cmd == CMD_LOAD) begin
			ld_ok_q <= ld_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && sym.cmd == CMD_LOAD) begin
			ld_row_q <= ld_row;
			ld_tap_q <= ld_tap;
			ld_val_q <= sym.coef_value;
		end
	end

	pif_ram #(
		.WIDTH (ROW_W),
		.DEPTH (PHASE_COUNT)
	) u_coef_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ld_row_q),
		.wr_data (wr_row),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// datapath
	always_comb begin
		for (int k = 0; k < TAPS_PER_PHASE_N; k++) begin
			prod[k] = PROD_W'(hist_q[k]) * PROD_W'(signed'(rd_data[k * COEF_W +: COEF_W]));
		end
	end

	always_comb begin
		acc = '0;
		for (int k = 0; k < TAPS_PER_PHASE_N; k++) begin
			acc = acc + ACC_W'(prod_s2[k]);
		end
	end

	always_comb begin
		idle_ext = signed'(SUM_W'({idle_q, {COEF_FRAC_BITS{1'b0}}}));
		sum      = idle_ext + SUM_W'(acc_s3) * GAIN;
		if (sum[SUM_W-1]) begin
			sample = '0;
		end else if (|sum[SUM_W-2:COEF_FRAC_BITS+DAC_W]) begin
			sample = '1;
		end else begin
			sample = sum[COEF_FRAC_BITS +: DAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= issue && (ph_q == PH_LAST);
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_q  <= last_s3;
			for (int k = 0; k < TAPS_PER_PHASE_N; k++) begin
				prod_s2[k] <= prod[k];
			end
			acc_s3 <= acc;
			dac_q  <= sample;
		end
	end

	assign dac.valid      = out_valid_q;
	assign dac.dac_sample = dac_q;
	assign dac.last_phase = last_q;

	// checks
	`PIF_ASSERT_IMPL(a_load_no_pending_read, state_q == ST_LOAD, !v_s1, "load read clobbers held row")
	`PIF_ASSERT_NEXT(a_last_phase_ends, issue && en && ph_q == PH_LAST, state_q == ST_IDLE, "filter does not end after last phase")
	`PIF_ASSERT_IMPL(a_phase_idle_zero, state_q != ST_FILT, ph_q == '0, "phase counter runs outside filtering")
	`PIF_ASSERT_NEXT(a_history_hold, !(accept && sym.cmd == CMD_FILTER), hist_q[0] == $past(hist_q[0]), "history moved without a symbol")
endmodule

// ===== src/pif_ram.sv =====
// generic single-port-write ram with registered read and read enable
// no dependencies
`timescale 1ns / 1ps
module pif_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
